FILE: rtl/bpfu_pkg.sv
package bpfu_pkg;

	localparam int COUNT_BITS = 48;
	localparam int WEIGHT_W   = 20;
	localparam int TRIALS_W   = 24;
	localparam int MEAN_W     = 17;
	localparam int PROD_W     = WEIGHT_W + TRIALS_W;
	localparam int FRAC_SHIFT = 6;
	localparam int INC_W      = PROD_W - FRAC_SHIFT;
	localparam int SUM_W      = ((COUNT_BITS > INC_W) ? COUNT_BITS : INC_W) + 1;
	localparam int DEN_W      = COUNT_BITS + 1;
	localparam bit WIDE_DEN   = (COUNT_BITS >= 64);
	localparam int DIV_STEPS  = MEAN_W;
	localparam int STEP_CNT_W = $clog2(DIV_STEPS);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(65536);
	localparam logic [TRIALS_W-1:0]   TRIALS_RESET = TRIALS_W'(6554);

	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 2;
	localparam int PADDR_W   = 3;
	localparam logic [PADDR_W-1:0] ADDR_TRIALS = 3'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_DINIT,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic mul;
		logic acc;
		logic div_init;
		logic div_step;
		logic div_first;
	} lane_ctrl_t;

	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic              sat;
	} lane_res_t;

endpackage

FILE: rtl/beta_posterior_fraction_updater_core.sv
// Keeps Beta posteriors for the recyclable and compostable fractions of each bin report
// and returns both posterior means in Q1.16 for every transfer taken. Two lanes, one per
// stream, scale the clamped part weights by trials_per_kg, add them to their saturating
// Q32.16 pseudo-counts and divide alpha by alpha plus beta with a restoring divider that
// yields one quotient bit per cycle. After the input transfer, an item passes through the
// multipliers, the accumulators, the divider set-up and 17 divider steps, then the result
// is loaded into the output register once that register is free. A new input is taken
// as soon as that result is loaded, even while it still waits to be transferred. A report
// with zero total weight leaves the counts unchanged and sets update_skipped.
module beta_posterior_fraction_updater_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// gross_weight[19:0], recyclable_weight[39:20], compostable_weight[59:40]
	input  logic [bpfu_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// recyclable_mean[16:0], compostable_mean[33:17]
	output logic [bpfu_pkg::M_TDATA_W-1:0]   m_tdata,
	// update_skipped[0], count_saturated[1]
	output logic [bpfu_pkg::M_TUSER_W-1:0]   m_tuser,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bpfu_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	bpfu_pkg::state_t state_q, state_n;
	logic [bpfu_pkg::TRIALS_W-1:0]   trials_q;
	logic [bpfu_pkg::WEIGHT_W-1:0]   total_q, rec_q, comp_q;
	logic                            skip_q;
	logic [bpfu_pkg::STEP_CNT_W-1:0] cnt_q;
	bpfu_pkg::lane_ctrl_t            ctrl;
	bpfu_pkg::lane_res_t             rec_res, comp_res;
	logic                            out_free, out_load, in_xfer;

	assign pready  = 1'b1;
	assign prdata  = 32'(trials_q);
	assign in_xfer = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trials_q <= bpfu_pkg::TRIALS_RESET;
		end else if (psel && penable && pwrite && paddr == bpfu_pkg::ADDR_TRIALS) begin
			trials_q <= pwdata[bpfu_pkg::TRIALS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			total_q <= s_tdata[bpfu_pkg::WEIGHT_W-1:0];
			rec_q   <= s_tdata[2*bpfu_pkg::WEIGHT_W-1:bpfu_pkg::WEIGHT_W];
			comp_q  <= s_tdata[3*bpfu_pkg::WEIGHT_W-1:2*bpfu_pkg::WEIGHT_W];
			skip_q  <= (s_tdata[bpfu_pkg::WEIGHT_W-1:0] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpfu_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == bpfu_pkg::ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_n  = state_q;
		ctrl     = '0;
		s_tready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			bpfu_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_n = bpfu_pkg::ST_MUL;
				end
			end
			bpfu_pkg::ST_MUL: begin
				ctrl.mul = 1'b1;
				state_n  = bpfu_pkg::ST_ACC;
			end
			bpfu_pkg::ST_ACC: begin
				ctrl.acc = !skip_q;
				state_n  = bpfu_pkg::ST_DINIT;
			end
			bpfu_pkg::ST_DINIT: begin
				ctrl.div_init = 1'b1;
				state_n       = bpfu_pkg::ST_DIV;
			end
			bpfu_pkg::ST_DIV: begin
				ctrl.div_step  = 1'b1;
				ctrl.div_first = (cnt_q == '0);
				if (cnt_q == bpfu_pkg::STEP_CNT_W'(bpfu_pkg::DIV_STEPS - 1)) begin
					state_n = bpfu_pkg::ST_DONE;
				end
			end
			bpfu_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_n  = bpfu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = bpfu_pkg::ST_IDLE;
			end
		endcase
	end

	bpfu_lane u_lane_rec (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.total  (total_q),
		.part   (rec_q),
		.trials (trials_q),
		.res    (rec_res)
	);

	bpfu_lane u_lane_comp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.total  (total_q),
		.part   (comp_q),
		.trials (trials_q),
		.res    (comp_res)
	);

	bpfu_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.rec_res  (rec_res),
		.comp_res (comp_res),
		.skipped  (skip_q),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.free     (out_free)
	);

endmodule

FILE: rtl/bpfu_lane.sv
module bpfu_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpfu_pkg::lane_ctrl_t          ctrl,
	input  logic [bpfu_pkg::WEIGHT_W-1:0] total,
	input  logic [bpfu_pkg::WEIGHT_W-1:0] part,
	input  logic [bpfu_pkg::TRIALS_W-1:0] trials,
	output bpfu_pkg::lane_res_t           res
);

	logic [bpfu_pkg::COUNT_BITS-1:0] alpha_q, beta_q;
	logic [bpfu_pkg::PROD_W-1:0]     prod_a_s1, prod_b_s1;
	logic [bpfu_pkg::DEN_W-1:0]      den_q, rem_q;
	logic [bpfu_pkg::MEAN_W-1:0]     quo_q;
	logic                            dz_q;

	logic [bpfu_pkg::WEIGHT_W-1:0] part_c;
	logic [bpfu_pkg::SUM_W-1:0]    sum_a, sum_b;
	logic [bpfu_pkg::COUNT_BITS-1:0] alpha_n, beta_n;
	logic [bpfu_pkg::DEN_W-1:0]    den_full, den_half, den_n, rem_n;
	logic                          den_wide;
	logic [bpfu_pkg::DEN_W:0]      cmp_val, den_x;
	logic                          take;

	always_comb begin
		part_c = (part > total) ? total : part;

		sum_a = bpfu_pkg::SUM_W'(alpha_q) + bpfu_pkg::SUM_W'(prod_a_s1[bpfu_pkg::PROD_W-1:
			bpfu_pkg::FRAC_SHIFT]);
		sum_b = bpfu_pkg::SUM_W'(beta_q) + bpfu_pkg::SUM_W'(prod_b_s1[bpfu_pkg::PROD_W-1:
			bpfu_pkg::FRAC_SHIFT]);
		alpha_n = (sum_a > bpfu_pkg::SUM_W'(bpfu_pkg::COUNT_MAX)) ? bpfu_pkg::COUNT_MAX :
			sum_a[bpfu_pkg::COUNT_BITS-1:0];
		beta_n = (sum_b > bpfu_pkg::SUM_W'(bpfu_pkg::COUNT_MAX)) ? bpfu_pkg::COUNT_MAX :
			sum_b[bpfu_pkg::COUNT_BITS-1:0];

		den_full = bpfu_pkg::DEN_W'(alpha_q) + bpfu_pkg::DEN_W'(beta_q);
		den_half = bpfu_pkg::DEN_W'(alpha_q >> 1) + bpfu_pkg::DEN_W'(beta_q >> 1);
		den_wide = bpfu_pkg::WIDE_DEN && den_full[bpfu_pkg::COUNT_BITS];
		den_n    = den_wide ? den_half : den_full;
		rem_n    = den_wide ? bpfu_pkg::DEN_W'(alpha_q >> 1) : bpfu_pkg::DEN_W'(alpha_q);

		cmp_val = ctrl.div_first ? {1'b0, rem_q} : {rem_q, 1'b0};
		den_x   = {1'b0, den_q};
		take    = (cmp_val >= den_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= bpfu_pkg::COUNT_RESET;
			beta_q  <= bpfu_pkg::COUNT_RESET;
		end else if (ctrl.acc) begin
			alpha_q <= alpha_n;
			beta_q  <= beta_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_a_s1 <= bpfu_pkg::PROD_W'(part_c) * bpfu_pkg::PROD_W'(trials);
			prod_b_s1 <= bpfu_pkg::PROD_W'(total - part_c) * bpfu_pkg::PROD_W'(trials);
		end
		if (ctrl.div_init) begin
			den_q <= den_n;
			rem_q <= rem_n;
			dz_q  <= (den_n == '0);
			quo_q <= '0;
		end else if (ctrl.div_step) begin
			if (take) begin
				rem_q <= bpfu_pkg::DEN_W'(cmp_val - den_x);
			end else begin
				rem_q <= cmp_val[bpfu_pkg::DEN_W-1:0];
			end
			quo_q <= {quo_q[bpfu_pkg::MEAN_W-2:0], take};
		end
	end

	assign res.mean = dz_q ? '0 : quo_q;
	assign res.sat  = (alpha_q == bpfu_pkg::COUNT_MAX) || (beta_q == bpfu_pkg::COUNT_MAX);

endmodule

FILE: rtl/bpfu_merge.sv
module bpfu_merge (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  bpfu_pkg::lane_res_t              rec_res,
	input  bpfu_pkg::lane_res_t              comp_res,
	input  logic                             skipped,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	output logic [bpfu_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [bpfu_pkg::M_TUSER_W-1:0]   m_tuser,
	output logic                             free
);

	logic                           valid_q;
	logic [bpfu_pkg::M_TDATA_W-1:0] data_q;
	logic [bpfu_pkg::M_TUSER_W-1:0] user_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= bpfu_pkg::M_TDATA_W'({comp_res.mean, rec_res.mean});
			user_q <= {rec_res.sat | comp_res.sat, skipped};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

endmodule

FILE: test/tb_beta_posterior_fraction_updater_core.sv
module tb_beta_posterior_fraction_updater_core;

	localparam logic [bpfu_pkg::WEIGHT_W-1:0] WEIGHT_MAX  = '1;
	localparam logic [bpfu_pkg::PADDR_W-1:0]  ADDR_UNUSED = 3'd4;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 30;
	localparam int DRIVE_ITEMS   = 1060;
	localparam int QUIET_ITEMS   = 150;
	localparam int SUM_BITS      = bpfu_pkg::COUNT_BITS + 1;
	localparam int NUM_BITS      = bpfu_pkg::COUNT_BITS + 17;

	typedef struct {
		logic [bpfu_pkg::MEAN_W-1:0] rec_mean;
		logic [bpfu_pkg::MEAN_W-1:0] comp_mean;
		logic                        skipped;
		logic                        saturated;
	} fraction_t;

	typedef enum logic [1:0] {
		ROW_REPORT,
		ROW_WRITE
	} row_kind_t;

	typedef struct {
		row_kind_t                     kind;
		logic [bpfu_pkg::WEIGHT_W-1:0] total;
		logic [bpfu_pkg::WEIGHT_W-1:0] rec;
		logic [bpfu_pkg::WEIGHT_W-1:0] comp;
		logic [bpfu_pkg::PADDR_W-1:0]  addr;
		logic [31:0]                   value;
		logic                          typed;
		fraction_t                     want;
	} stim_row_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	// gross_weight[19:0], recyclable_weight[39:20], compostable_weight[59:40]
	logic [bpfu_pkg::S_TDATA_W-1:0]   s_tdata;
	logic                             m_tvalid;
	logic                             m_tready;
	// recyclable_mean[16:0], compostable_mean[33:17]
	logic [bpfu_pkg::M_TDATA_W-1:0]   m_tdata;
	// update_skipped[0], count_saturated[1]
	logic [bpfu_pkg::M_TUSER_W-1:0]   m_tuser;
	logic                             psel;
	logic                             penable;
	logic                             pwrite;
	logic [bpfu_pkg::PADDR_W-1:0]     paddr;
	logic [31:0]                      pwdata;
	logic [31:0]                      prdata;
	logic                             pready;

	logic [bpfu_pkg::TRIALS_W-1:0]    kg_trials;
	logic [bpfu_pkg::COUNT_BITS-1:0]  rec_alpha;
	logic [bpfu_pkg::COUNT_BITS-1:0]  rec_beta;
	logic [bpfu_pkg::COUNT_BITS-1:0]  comp_alpha;
	logic [bpfu_pkg::COUNT_BITS-1:0]  comp_beta;

	fraction_t pending_fractions[$];
	stim_row_t directed_rows[$];
	int mismatches;
	int reports_sent;
	int skipped_seen;
	int saturated_seen;
	int trials_writes;
	bit gaps_on;

	beta_posterior_fraction_updater_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * 400000);
		$display("Timeout with %0d results outstanding.", pending_fractions.size());
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("Mismatch on %s: expected %0h, got %0h", what, want, got);
		end
	endtask

	function automatic logic [bpfu_pkg::COUNT_BITS-1:0] grow_count(
			input logic [bpfu_pkg::COUNT_BITS-1:0] acc,
			input logic [bpfu_pkg::WEIGHT_W-1:0] weight);
		logic [bpfu_pkg::PROD_W-1:0] prod;
		logic [SUM_BITS-1:0]         sum;
		prod = bpfu_pkg::PROD_W'(weight) * bpfu_pkg::PROD_W'(kg_trials);
		sum = {1'b0, acc} + SUM_BITS'(prod >> bpfu_pkg::FRAC_SHIFT);
		if (sum >= {1'b0, bpfu_pkg::COUNT_MAX}) begin
			return bpfu_pkg::COUNT_MAX;
		end
		return sum[bpfu_pkg::COUNT_BITS-1:0];
	endfunction

	function automatic logic [bpfu_pkg::MEAN_W-1:0] posterior_mean(
			input logic [bpfu_pkg::COUNT_BITS-1:0] a,
			input logic [bpfu_pkg::COUNT_BITS-1:0] b);
		logic [SUM_BITS-1:0] den;
		logic [NUM_BITS-1:0] num;
		logic [NUM_BITS-1:0] quo;
		den = {1'b0, a} + {1'b0, b};
		if (den == '0) begin
			return '0;
		end
		num = {1'b0, a, 16'b0};
		quo = num / NUM_BITS'(den);
		return quo[bpfu_pkg::MEAN_W-1:0];
	endfunction

	task automatic predict_fractions(input logic [bpfu_pkg::WEIGHT_W-1:0] total,
			input logic [bpfu_pkg::WEIGHT_W-1:0] rec,
			input logic [bpfu_pkg::WEIGHT_W-1:0] comp,
			output fraction_t res);
		logic [bpfu_pkg::WEIGHT_W-1:0] rec_part;
		logic [bpfu_pkg::WEIGHT_W-1:0] comp_part;
		if (total != 0) begin
			rec_part = (rec > total) ? total : rec;
			comp_part = (comp > total) ? total : comp;
			rec_alpha = grow_count(rec_alpha, rec_part);
			rec_beta = grow_count(rec_beta, total - rec_part);
			comp_alpha = grow_count(comp_alpha, comp_part);
			comp_beta = grow_count(comp_beta, total - comp_part);
		end
		res.skipped = (total == 0);
		res.saturated = (rec_alpha == bpfu_pkg::COUNT_MAX) ||
			(rec_beta == bpfu_pkg::COUNT_MAX) ||
			(comp_alpha == bpfu_pkg::COUNT_MAX) || (comp_beta == bpfu_pkg::COUNT_MAX);
		res.rec_mean = posterior_mean(rec_alpha, rec_beta);
		res.comp_mean = posterior_mean(comp_alpha, comp_beta);
	endtask

	task automatic send_report(input logic [bpfu_pkg::WEIGHT_W-1:0] total,
			input logic [bpfu_pkg::WEIGHT_W-1:0] rec,
			input logic [bpfu_pkg::WEIGHT_W-1:0] comp,
			input logic typed, input fraction_t want);
		fraction_t res;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = bpfu_pkg::S_TDATA_W'({comp, rec, total});
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		predict_fractions(total, rec, comp, res);
		pending_fractions.insert(pending_fractions.size(), typed ? want : res);
		reports_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_fractions.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_write(input logic [bpfu_pkg::PADDR_W-1:0] addr,
			input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		if (addr == bpfu_pkg::ADDR_TRIALS) begin
			kg_trials = data[bpfu_pkg::TRIALS_W-1:0];
			trials_writes++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		psel = 1'b1;
		paddr = bpfu_pkg::ADDR_TRIALS;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		if (prdata !== 32'(kg_trials)) begin
			report_mismatch("prdata trials_per_kg", 64'(kg_trials), 64'(prdata));
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	function automatic logic [bpfu_pkg::WEIGHT_W-1:0] pick_total();
		case ($urandom_range(0, 15))
			0: return '0;
			1, 2: return bpfu_pkg::WEIGHT_W'($urandom_range(1, 64));
			3, 4: return WEIGHT_MAX;
			default: return bpfu_pkg::WEIGHT_W'($urandom());
		endcase
	endfunction

	function automatic logic [bpfu_pkg::WEIGHT_W-1:0] pick_part(
			input logic [bpfu_pkg::WEIGHT_W-1:0] total);
		case ($urandom_range(0, 3))
			0: return bpfu_pkg::WEIGHT_W'($urandom());
			1: return total;
			2: return '0;
			default: return bpfu_pkg::WEIGHT_W'($urandom_range(0, total));
		endcase
	endfunction

	function automatic stim_row_t report_row(input logic [bpfu_pkg::WEIGHT_W-1:0] total,
			input logic [bpfu_pkg::WEIGHT_W-1:0] rec,
			input logic [bpfu_pkg::WEIGHT_W-1:0] comp);
		stim_row_t row;
		row.kind = ROW_REPORT;
		row.total = total;
		row.rec = rec;
		row.comp = comp;
		row.addr = bpfu_pkg::ADDR_TRIALS;
		row.value = '0;
		row.typed = 1'b0;
		row.want = '{'0, '0, 1'b0, 1'b0};
		return row;
	endfunction

	function automatic stim_row_t known_row(input logic [bpfu_pkg::WEIGHT_W-1:0] total,
			input logic [bpfu_pkg::WEIGHT_W-1:0] rec,
			input logic [bpfu_pkg::WEIGHT_W-1:0] comp,
			input fraction_t want);
		stim_row_t row;
		row = report_row(total, rec, comp);
		row.typed = 1'b1;
		row.want = want;
		return row;
	endfunction

	function automatic stim_row_t write_row(input logic [bpfu_pkg::PADDR_W-1:0] addr,
			input logic [31:0] value);
		stim_row_t row;
		row = report_row('0, '0, '0);
		row.kind = ROW_WRITE;
		row.addr = addr;
		row.value = value;
		return row;
	endfunction

	function automatic void add_row(input stim_row_t row);
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				stall_left = $urandom_range(1, 13) - 1;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		fraction_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (pending_fractions.size() == 0) begin
				report_mismatch("unexpected result", '0, 64'(m_tdata));
			end else begin
				want = pending_fractions.pop_front();
				if (m_tdata[bpfu_pkg::MEAN_W-1:0] !== want.rec_mean) begin
					report_mismatch("recyclable_mean", 64'(want.rec_mean),
						64'(m_tdata[bpfu_pkg::MEAN_W-1:0]));
				end
				if (m_tdata[2*bpfu_pkg::MEAN_W-1:bpfu_pkg::MEAN_W] !== want.comp_mean) begin
					report_mismatch("compostable_mean", 64'(want.comp_mean),
						64'(m_tdata[2*bpfu_pkg::MEAN_W-1:bpfu_pkg::MEAN_W]));
				end
				if (m_tuser[0] !== want.skipped) begin
					report_mismatch("update_skipped", 64'(want.skipped), 64'(m_tuser[0]));
				end
				if (m_tuser[1] !== want.saturated) begin
					report_mismatch("count_saturated", 64'(want.saturated), 64'(m_tuser[1]));
				end
				if (want.skipped) skipped_seen++;
				if (want.saturated) saturated_seen++;
			end
		end
	end

	initial begin
		fraction_t half_skip;
		fraction_t half_kept;
		fraction_t none;
		logic [bpfu_pkg::WEIGHT_W-1:0] total;
		logic [31:0] trials_choice;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = bpfu_pkg::ADDR_TRIALS;
		pwdata = '0;
		mismatches = 0;
		reports_sent = 0;
		skipped_seen = 0;
		saturated_seen = 0;
		trials_writes = 0;
		gaps_on = 1'b1;
		kg_trials = bpfu_pkg::TRIALS_RESET;
		rec_alpha = bpfu_pkg::COUNT_RESET;
		rec_beta = bpfu_pkg::COUNT_RESET;
		comp_alpha = bpfu_pkg::COUNT_RESET;
		comp_beta = bpfu_pkg::COUNT_RESET;
		half_skip = '{17'd32768, 17'd32768, 1'b1, 1'b0};
		half_kept = '{17'd32768, 17'd32768, 1'b0, 1'b0};
		none = '{'0, '0, 1'b0, 1'b0};

		// With no trials added, the uniform prior keeps both means at one half.
		add_row(known_row('0, '0, '0, half_skip));
		add_row(known_row('0, WEIGHT_MAX, WEIGHT_MAX, half_skip));
		add_row(write_row(bpfu_pkg::ADDR_TRIALS, 32'd0));
		add_row(known_row(WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX, half_kept));
		add_row(known_row(WEIGHT_MAX, '0, '0, half_kept));
		add_row(write_row(ADDR_UNUSED, 32'h00FF_FFFF));
		add_row(known_row(20'd1, 20'd1, '0, half_kept));
		add_row(write_row(bpfu_pkg::ADDR_TRIALS, 32'(bpfu_pkg::TRIALS_RESET)));
		add_row(report_row(20'd64, 20'd64, '0));
		add_row(report_row(20'd64, '0, 20'd64));
		add_row(report_row(20'd100, 20'd500, 20'd1000));
		add_row(report_row(WEIGHT_MAX, WEIGHT_MAX, '0));
		add_row(report_row(WEIGHT_MAX, '0, WEIGHT_MAX));
		add_row(report_row(20'd1, '0, 20'd1));
		add_row(report_row('0, 20'd12345, 20'd54321));
		add_row(write_row(bpfu_pkg::ADDR_TRIALS, 32'hFFFF_FFFF));
		add_row(report_row(WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX));
		add_row(report_row(WEIGHT_MAX, 20'hAAAAA, 20'h55555));
		add_row(report_row(20'h55555, 20'hAAAAA, 20'h2AAAA));
		add_row(write_row(bpfu_pkg::ADDR_TRIALS, 32'd1));
		add_row(report_row(20'd1, 20'd1, 20'd1));
		add_row(report_row(20'd63, 20'd63, '0));
		add_row(report_row(20'd64, 20'd64, 20'd64));
		add_row(report_row('0, '0, '0));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				settle();
				apb_write(directed_rows[i].addr, directed_rows[i].value);
			end else begin
				send_report(directed_rows[i].total, directed_rows[i].rec,
					directed_rows[i].comp, directed_rows[i].typed, directed_rows[i].want);
			end
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: trials_choice = 32'hFFFF_FFFF;
				1: trials_choice = 32'(bpfu_pkg::TRIALS_RESET);
				2: trials_choice = 32'd0;
				3: trials_choice = $urandom_range(1, 255);
				4: trials_choice = 32'h00FF_FFFF;
				default: trials_choice = $urandom();
			endcase
			settle();
			if ($urandom_range(0, 1) == 0) begin
				apb_write(ADDR_UNUSED, $urandom());
			end
			apb_write(bpfu_pkg::ADDR_TRIALS, trials_choice);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 39) == 0) begin
					settle();
				end
				total = pick_total();
				send_report(total, pick_part(total), pick_part(total), 1'b0, none);
			end
		end

		// Heavy reports at the largest scale drive the recyclable alpha count into saturation.
		settle();
		apb_write(bpfu_pkg::ADDR_TRIALS, 32'h00FF_FFFF);
		for (int k = 0; k < DRIVE_ITEMS; k++) begin
			if (k == DRIVE_ITEMS - QUIET_ITEMS) begin
				gaps_on = 1'b0;
			end
			if (k == DRIVE_ITEMS / 2) begin
				settle();
			end
			if ($urandom_range(0, 24) == 0) begin
				send_report('0, bpfu_pkg::WEIGHT_W'($urandom()),
					bpfu_pkg::WEIGHT_W'($urandom()), 1'b0, none);
			end else begin
				total = bpfu_pkg::WEIGHT_W'($urandom_range(WEIGHT_MAX - 63, WEIGHT_MAX));
				send_report(total, bpfu_pkg::WEIGHT_W'($urandom_range(total, WEIGHT_MAX)),
					pick_part(total), 1'b0, none);
			end
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_fractions.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("Ran %0d bin reports over %0d trials_per_kg writes.", reports_sent,
			trials_writes);
		$display("%0d reports had zero weight, %0d results showed saturated counts.",
			skipped_seen, saturated_seen);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches in total.", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
